@@ rtl/lrva_pkg.sv @@
package lrva_pkg;

  localparam int unsigned STATES_DEF     = 8;
  localparam int unsigned FRAME_BITS_DEF = 16;
  localparam int unsigned MAX_STATES     = 8;
  localparam int unsigned SCORE_W        = 32;
  localparam int unsigned FLOOR_W        = 29;
  localparam int unsigned OUT_FRAME_W    = 16;
  localparam int unsigned STATE_IDX_W    = 3;

  localparam logic signed [FLOOR_W-1:0] FLOOR_RESET = -29'sd262144;

  // 1.2 in Q.14
  localparam logic [14:0] SCALE_Q14   = 15'd19661;
  localparam int unsigned SCALE_SHIFT = 14;

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic signed [SCORE_W-1:0] score_state_0;
    logic signed [SCORE_W-1:0] score_state_1;
    logic signed [SCORE_W-1:0] score_state_2;
    logic signed [SCORE_W-1:0] score_state_3;
    logic signed [SCORE_W-1:0] score_state_4;
    logic signed [SCORE_W-1:0] score_state_5;
    logic signed [SCORE_W-1:0] score_state_6;
    logic signed [SCORE_W-1:0] score_state_7;
  } in_word_t;

  typedef struct packed {
    logic [STATE_IDX_W-1:0]    state_index;
    logic signed [SCORE_W-1:0] path_score;
    logic [OUT_FRAME_W-1:0]    boundary_frame;
    logic [OUT_FRAME_W-1:0]    frame_count;
    logic                      last_of_frame;
  } out_word_t;

  typedef struct packed {
    logic start;      // start frame accepted
    logic step;       // next frame accepted
    logic seed;       // seeding wave in progress
    logic seed_last;  // final seeding cycle
  } lrva_ctrl_t;

endpackage

@@ rtl/lrva_cell.sv @@
module lrva_cell #(
  parameter int unsigned STATES     = lrva_pkg::STATES_DEF,
  parameter int unsigned FRAME_BITS = lrva_pkg::FRAME_BITS_DEF,
  parameter int unsigned IDX        = 0
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  lrva_pkg::lrva_ctrl_t                       ctrl_i,
  input  logic signed [lrva_pkg::FLOOR_W-1:0]        floor_i,
  input  logic signed [lrva_pkg::SCORE_W-1:0]        score_i,
  input  logic signed [lrva_pkg::SCORE_W-1:0]        nb_score_i,
  input  logic        [STATES-1:0][FRAME_BITS-1:0]   nb_row_i,
  input  logic        [FRAME_BITS-1:0]               fc_i,
  output logic signed [lrva_pkg::SCORE_W-1:0]        score_o,
  output logic        [STATES-1:0][FRAME_BITS-1:0]   row_o
);
  import lrva_pkg::*;

  function automatic logic signed [SCORE_W-1:0] sat32(input logic signed [SCORE_W+1:0] v);
    logic signed [SCORE_W-1:0] r;
    if (v > $signed({{2{1'b0}}, 1'b0, {(SCORE_W-1){1'b1}}})) begin
      r = {1'b0, {(SCORE_W-1){1'b1}}};
    end else if (v < $signed({{2{1'b1}}, 1'b1, {(SCORE_W-1){1'b0}}})) begin
      r = {1'b1, {(SCORE_W-1){1'b0}}};
    end else begin
      r = v[SCORE_W-1:0];
    end
    return r;
  endfunction

  // x * 1.2, round half away from zero, saturate
  function automatic logic signed [SCORE_W-1:0] scale12(input logic signed [SCORE_W-1:0] x);
    logic                      neg;
    logic [SCORE_W-1:0]        mag;
    logic [SCORE_W+14:0]       prod;
    logic [SCORE_W:0]          r;
    logic signed [SCORE_W+1:0] v;
    neg  = x[SCORE_W-1];
    mag  = neg ? (~x + 1'b1) : x;
    prod = {15'd0, mag} * {{SCORE_W{1'b0}}, SCALE_Q14};
    prod = prod + (SCORE_W+15)'(1 << (SCALE_SHIFT - 1));
    r    = prod[SCALE_SHIFT +: (SCORE_W+1)];
    v    = $signed({1'b0, r});
    if (neg) begin
      v = -v;
    end
    return sat32(v);
  endfunction

  logic signed [SCORE_W-1:0]     score_q, score_d;
  logic [STATES-1:0][FRAME_BITS-1:0] row_q, row_d;
  logic                          take;
  logic signed [SCORE_W-1:0]     base;

  always_comb begin
    take    = (IDX != 0) && (nb_score_i > score_q);
    base    = take ? nb_score_i : score_q;
    score_d = score_q;
    row_d   = row_q;
    if (ctrl_i.start) begin
      row_d = '0;
      if (IDX == 0) begin
        score_d = SCORE_W'(floor_i);
      end
    end else if (ctrl_i.seed) begin
      if (IDX == 0) begin
        if (ctrl_i.seed_last) begin
          score_d = score_i;
        end
      end else begin
        score_d = scale12(nb_score_i);
      end
    end else if (ctrl_i.step) begin
      score_d = sat32((SCORE_W+2)'(base) + (SCORE_W+2)'(score_i));
      if (take) begin
        for (int i = 1; i < STATES; i++) begin
          if (i == IDX) begin
            row_d[i] = fc_i;
          end else if (i < IDX) begin
            row_d[i] = nb_row_i[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q <= '0;
      row_q   <= '0;
    end else begin
      score_q <= score_d;
      row_q   <= row_d;
    end
  end

  assign score_o = score_q;
  assign row_o   = row_q;

endmodule

@@ rtl/left_right_viterbi_aligner.sv @@
// channel  valid        stall        payload
// in       in_valid_i   in_stall_o   in_word_i  (lrva_pkg::in_word_t)
// out      out_valid_o  out_stall_i  out_word_o (lrva_pkg::out_word_t)
// cfg      cfg_we_i     -            cfg_data_i (initial_floor)
//
// Next frame: all cells update at once on accept, then STATES output words.
// Start frame: a load step, then seeding steps (scale wave down the cell chain,
// one 32x15 multiplier per cell other than cell 0), then STATES output words.
// One frame at a time: in_stall_o is high from accept until the last word leaves.
// Output stall holds the current word; the cells do not change meanwhile.
// Reset clears scores, entry frames and frame count; floor resets to -262144.
module left_right_viterbi_aligner #(
  parameter int unsigned STATES     = lrva_pkg::STATES_DEF,
  parameter int unsigned FRAME_BITS = lrva_pkg::FRAME_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic signed [lrva_pkg::FLOOR_W-1:0]   cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  lrva_pkg::in_word_t                    in_word_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output lrva_pkg::out_word_t                   out_word_o
);
  import lrva_pkg::*;

  localparam int unsigned IDX_W  = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int unsigned FB_EXT = (FRAME_BITS > OUT_FRAME_W) ? FRAME_BITS : OUT_FRAME_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SEED = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                    state_q, state_d;
  logic [IDX_W-1:0]          cnt_q, cnt_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic                      out_valid_q, out_valid_d;
  logic [FRAME_BITS-1:0]     fc_q, fc_d;
  logic signed [FLOOR_W-1:0] floor_q;
  logic signed [SCORE_W-1:0] sc0_q;

  logic                      in_acc;
  lrva_ctrl_t                ctrl;
  logic [MAX_STATES-1:0][SCORE_W-1:0]         scores;
  logic [STATES-1:0][SCORE_W-1:0]             path;
  logic [STATES-1:0][STATES-1:0][FRAME_BITS-1:0] rows;
  logic [FB_EXT-1:0]         bext;
  logic [FB_EXT-1:0]         fext;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign scores[0] = in_word_i.score_state_0;
  assign scores[1] = in_word_i.score_state_1;
  assign scores[2] = in_word_i.score_state_2;
  assign scores[3] = in_word_i.score_state_3;
  assign scores[4] = in_word_i.score_state_4;
  assign scores[5] = in_word_i.score_state_5;
  assign scores[6] = in_word_i.score_state_6;
  assign scores[7] = in_word_i.score_state_7;

  always_comb begin
    ctrl.start     = in_acc && (in_word_i.operation == OP_START);
    ctrl.step      = in_acc && (in_word_i.operation == OP_NEXT);
    ctrl.seed      = (state_q == ST_SEED);
    ctrl.seed_last = ctrl.seed && (cnt_q == IDX_W'(STATES - 2));
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    fc_d        = fc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ctrl.start) begin
          state_d = ST_SEED;
          cnt_d   = '0;
          fc_d    = FRAME_BITS'(1);
        end else if (ctrl.step) begin
          state_d     = ST_EMIT;
          idx_d       = '0;
          out_valid_d = 1'b1;
          if (!(&fc_q)) begin
            fc_d = fc_q + 1'b1;
          end
        end
      end
      ST_SEED: begin
        if (ctrl.seed_last) begin
          state_d     = ST_EMIT;
          idx_d       = '0;
          out_valid_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          if (idx_q == IDX_W'(STATES - 1)) begin
            state_d     = ST_IDLE;
            out_valid_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      fc_q        <= '0;
      floor_q     <= FLOOR_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      fc_q        <= fc_d;
      if (cfg_we_i) begin
        floor_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.start) begin
      sc0_q <= in_word_i.score_state_0;
    end
  end

  for (genvar s = 0; s < STATES; s++) begin : g_cell
    logic signed [SCORE_W-1:0]         cell_score;
    logic signed [SCORE_W-1:0]         nb_score;
    logic [STATES-1:0][FRAME_BITS-1:0] nb_row;
    if (s == 0) begin : g_head
      assign cell_score = ctrl.seed ? sc0_q : $signed(scores[0]);
      assign nb_score   = '0;
      assign nb_row     = '0;
    end else begin : g_body
      assign cell_score = scores[s];
      assign nb_score   = path[s-1];
      assign nb_row     = rows[s-1];
    end
    lrva_cell #(
      .STATES     (STATES),
      .FRAME_BITS (FRAME_BITS),
      .IDX        (s)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .floor_i    (floor_q),
      .score_i    (cell_score),
      .nb_score_i (nb_score),
      .nb_row_i   (nb_row),
      .fc_i       (fc_q),
      .score_o    (path[s]),
      .row_o      (rows[s])
    );
  end

  assign bext = FB_EXT'(rows[STATES-1][idx_q]);
  assign fext = FB_EXT'(fc_q);

  always_comb begin
    out_word_o.state_index    = STATE_IDX_W'(idx_q);
    out_word_o.path_score     = path[idx_q];
    out_word_o.boundary_frame = bext[OUT_FRAME_W-1:0];
    out_word_o.frame_count    = fext[OUT_FRAME_W-1:0];
    out_word_o.last_of_frame  = (idx_q == IDX_W'(STATES - 1));
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/lrva_checker.sv @@
module lrva_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lrva_pkg::out_word_t out_word_o
);
  import lrva_pkg::*;

  logic out_acc;
  assign out_acc = out_valid_o && !out_stall_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_busy_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while results pending");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o || out_valid_o &&
      out_word_o.state_index == '0)
    else $error("frame accepted without going busy");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_word_o.last_of_frame |=> !out_valid_o && !in_stall_o)
    else $error("block not idle after last word");

  a_index_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_word_o.last_of_frame |=> out_valid_o &&
      out_word_o.state_index == STATE_IDX_W'($past(out_word_o.state_index) + 1'b1))
    else $error("state index sequence broken");

endmodule

bind left_right_viterbi_aligner lrva_checker u_lrva_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import lrva_pkg::*;

  localparam int unsigned NSTATES    = STATES_DEF;
  localparam int unsigned LIMIT      = 3000000;
  localparam int unsigned MAX_PRINTS = 100;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic signed [FLOOR_W-1:0] cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  in_word_t                  in_word_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  out_word_t                 out_word_o;

  left_right_viterbi_aligner u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // aligner shadow state
  logic signed [SCORE_W-1:0]     path_m [MAX_STATES];
  logic [OUT_FRAME_W-1:0]        entry_m [MAX_STATES][MAX_STATES];
  logic [OUT_FRAME_W-1:0]        frames_m;
  logic signed [FLOOR_W-1:0]     floor_m;

  in_word_t  frame_q[$];
  out_word_t state_reports_q[$];

  int unsigned mismatches;
  int unsigned cycles;
  int unsigned send_gap;
  int unsigned stall_gap;
  logic        in_fire_q;
  logic        idle_en;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic signed [SCORE_W-1:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[SCORE_W-1:0];
  endfunction

  function automatic logic signed [SCORE_W-1:0] scale_step(input logic signed [SCORE_W-1:0] x);
    longint mag;
    longint r;
    mag = (x < 0) ? -longint'(x) : longint'(x);
    r = (mag * longint'(SCALE_Q14) + (64'sd1 <<< (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
    return sat32((x < 0) ? -r : r);
  endfunction

  task automatic align_frame(input in_word_t w);
    logic signed [SCORE_W-1:0] sc [MAX_STATES];
    out_word_t o;
    int s;
    int i;
    sc[0] = w.score_state_0;
    sc[1] = w.score_state_1;
    sc[2] = w.score_state_2;
    sc[3] = w.score_state_3;
    sc[4] = w.score_state_4;
    sc[5] = w.score_state_5;
    sc[6] = w.score_state_6;
    sc[7] = w.score_state_7;
    if (w.operation == OP_START) begin
      frames_m = OUT_FRAME_W'(1);
      for (s = 0; s < MAX_STATES; s++)
        for (i = 0; i < MAX_STATES; i++)
          entry_m[s][i] = '0;
      path_m[0] = SCORE_W'(floor_m);
      for (s = 1; s < NSTATES; s++)
        path_m[s] = scale_step(path_m[s-1]);
      path_m[0] = sc[0];
    end else begin
      for (s = NSTATES - 1; s > 0; s--) begin
        if (path_m[s-1] > path_m[s]) begin
          path_m[s] = path_m[s-1];
          entry_m[s][s] = frames_m;
          for (i = s - 1; i > 0; i--)
            entry_m[s][i] = entry_m[s-1][i];
        end
        path_m[s] = sat32(longint'(path_m[s]) + longint'(sc[s]));
      end
      path_m[0] = sat32(longint'(path_m[0]) + longint'(sc[0]));
      if (frames_m != '1) frames_m = frames_m + 1'b1;
    end
    for (s = 0; s < NSTATES; s++) begin
      o.state_index    = s[STATE_IDX_W-1:0];
      o.path_score     = path_m[s];
      o.boundary_frame = (s == 0) ? '0 : entry_m[NSTATES-1][s];
      o.frame_count    = frames_m;
      o.last_of_frame  = (s == NSTATES - 1);
      state_reports_q.push_back(o);
    end
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("MISMATCH %s: got %0h want %0h", what, got, want);
  endtask

  function automatic logic signed [SCORE_W-1:0] rand_score();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 8191)) - 32'sd4096;
    endcase
  endfunction

  function automatic in_word_t rand_frame(input logic op);
    in_word_t w;
    w.operation     = op;
    w.score_state_0 = rand_score();
    w.score_state_1 = rand_score();
    w.score_state_2 = rand_score();
    w.score_state_3 = rand_score();
    w.score_state_4 = rand_score();
    w.score_state_5 = rand_score();
    w.score_state_6 = rand_score();
    w.score_state_7 = rand_score();
    return w;
  endfunction

  function automatic in_word_t flat_frame(input logic op, input logic signed [SCORE_W-1:0] v);
    in_word_t w;
    w.operation     = op;
    w.score_state_0 = v;
    w.score_state_1 = v;
    w.score_state_2 = v;
    w.score_state_3 = v;
    w.score_state_4 = v;
    w.score_state_5 = v;
    w.score_state_6 = v;
    w.score_state_7 = v;
    return w;
  endfunction

  task automatic wait_idle();
    while (frame_q.size() != 0 || in_valid_i || state_reports_q.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_floor(input logic signed [FLOOR_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_fire_q) begin
    end else if (send_gap > 0) begin
      in_valid_i <= 1'b0;
      send_gap   <= send_gap - 1;
    end else if (frame_q.size() > 0) begin
      if (idle_en && $urandom_range(0, 3) == 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= $urandom_range(0, 2);
      end else begin
        in_word_i  <= frame_q.pop_front();
        in_valid_i <= 1'b1;
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // output backpressure
  always @(negedge clk_i) begin
    if (stall_gap > 0) begin
      out_stall_i <= 1'b1;
      stall_gap   <= stall_gap - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_gap   <= $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor and predictor
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      in_fire_q <= 1'b0;
    end else begin
      in_fire_q <= in_valid_i && !in_stall_o;
      if (cfg_we_i) floor_m = cfg_data_i;
      if (in_valid_i && !in_stall_o) align_frame(in_word_i);
      if (out_valid_o && !out_stall_i) begin
        if (state_reports_q.size() == 0) begin
          note_mismatch("unexpected word", 64'(out_word_o.path_score), '0);
        end else begin
          want = state_reports_q.pop_front();
          if (out_word_o.state_index !== want.state_index)
            note_mismatch("state_index", 64'(out_word_o.state_index),
                          64'(want.state_index));
          if (out_word_o.path_score !== want.path_score)
            note_mismatch("path_score", 64'(out_word_o.path_score),
                          64'(want.path_score));
          if (out_word_o.boundary_frame !== want.boundary_frame)
            note_mismatch("boundary_frame", 64'(out_word_o.boundary_frame),
                          64'(want.boundary_frame));
          if (out_word_o.frame_count !== want.frame_count)
            note_mismatch("frame_count", 64'(out_word_o.frame_count),
                          64'(want.frame_count));
          if (out_word_o.last_of_frame !== want.last_of_frame)
            note_mismatch("last_of_frame", 64'(out_word_o.last_of_frame),
                          64'(want.last_of_frame));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("left_right_viterbi_aligner verification failed");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    int ph;
    int n;
    int s;
    int i;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_stall_i = 1'b0;
    mismatches  = 0;
    cycles      = 0;
    send_gap    = 0;
    stall_gap   = 0;
    idle_en     = 1'b1;
    floor_m     = FLOOR_RESET;
    frames_m    = '0;
    for (s = 0; s < MAX_STATES; s++) begin
      path_m[s] = '0;
      for (i = 0; i < MAX_STATES; i++)
        entry_m[s][i] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // next frames before any start, then saturation both ways
    frame_q.push_back(flat_frame(OP_NEXT, 32'sd0));
    frame_q.push_back(flat_frame(OP_NEXT, 32'sh7FFFFFFF));
    w = rand_frame(OP_START);
    w.score_state_0 = 32'sh7FFFFFFF;
    frame_q.push_back(w);
    frame_q.push_back(flat_frame(OP_NEXT, 32'sh7FFFFFFF));
    frame_q.push_back(flat_frame(OP_NEXT, 32'sh80000000));
    frame_q.push_back(flat_frame(OP_NEXT, 32'sh80000000));
    // strong state 0 pulls the path rightward one state per frame
    frame_q.push_back(flat_frame(OP_START, 32'sd0));
    for (n = 0; n < 6; n++) begin
      w = flat_frame(OP_NEXT, 32'sd0);
      w.score_state_0 = 32'sd256000;
      frame_q.push_back(w);
    end
    frame_q.push_back(flat_frame(OP_NEXT, 32'shFFFFFFFF));
    w = flat_frame(OP_NEXT, 32'sh55555555);
    w.score_state_1 = 32'shAAAAAAAA;
    w.score_state_3 = 32'shAAAAAAAA;
    w.score_state_5 = 32'shAAAAAAAA;
    w.score_state_7 = 32'shAAAAAAAA;
    frame_q.push_back(w);
    wait_idle();

    set_floor(29'sd0);
    frame_q.push_back(rand_frame(OP_START));
    frame_q.push_back(flat_frame(OP_NEXT, 32'sd0));
    wait_idle();
    set_floor(-29'sd268435456);
    frame_q.push_back(rand_frame(OP_START));
    frame_q.push_back(flat_frame(OP_NEXT, 32'sd100));
    wait_idle();
    set_floor(29'sh0FFFFFFF);
    frame_q.push_back(flat_frame(OP_START, -32'sd1));
    frame_q.push_back(rand_frame(OP_NEXT));
    wait_idle();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_floor(-$signed(29'($urandom_range(0, 268435456))));
        1: set_floor(FLOOR_W'($urandom));
        2: set_floor(FLOOR_RESET);
        default: set_floor(-$signed(29'($urandom_range(0, 4096))));
      endcase
      idle_en = (ph != 3);
      n = 0;
      while (n < 25) begin
        frame_q.push_back(rand_frame(OP_START));
        n++;
        for (i = $urandom_range(1, 8); i > 0 && n < 25; i--) begin
          frame_q.push_back(rand_frame(($urandom_range(0, 9) == 0) ? OP_START : OP_NEXT));
          n++;
        end
      end
      wait_idle();
    end
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && state_reports_q.size() == 0) begin
      $display("left_right_viterbi_aligner verification clean");
    end else begin
      $display("left_right_viterbi_aligner verification failed");
    end
    $finish;
  end

endmodule
